// ===== hw/rtl/tcw_pkg.sv =====
// Package for the text console writer: shared constants, command codes and
// control character codes. No dependencies; used by every module of the block.
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CELL_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;

    // Blank cell: character 0 with light-grey-on-black attribute.
    localparam logic [ATTR_W-1:0] BLANK_ATTR = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h00;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    localparam int TAB_STOP = 8;

    // APB register map: one 32-bit word per register.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TEXT_ATTRIBUTE = 1'b0;

endpackage

// ===== hw/rtl/tcw_cell_ram.sv =====
// Screen cell store: one write port, one read port with a registered read.
// Depends on tcw_pkg for the cell width.
module tcw_cell_ram #(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tcw_pkg::CELL_W-1:0]  rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tcw_apb_regs.sv =====
// APB configuration register block holding the text attribute byte.
// Depends on tcw_pkg for the register map and reset value.
module tcw_apb_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output logic [tcw_pkg::ATTR_W-1:0]    text_attribute
);

    logic [tcw_pkg::ATTR_W-1:0] text_attribute_reg;
    logic                       sel_attr;

    // Registers sit on 32-bit words, so the index starts at address bit 2.
    assign sel_attr = (paddr[2] == tcw_pkg::REG_TEXT_ATTRIBUTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attribute_reg <= tcw_pkg::ATTR_RESET;
        end
        else if (psel && penable && pwrite && sel_attr)
        begin
            text_attribute_reg <= pwdata[tcw_pkg::ATTR_W-1:0];
        end
    end

    assign prdata         = sel_attr ? tcw_pkg::PDATA_W'(text_attribute_reg) : '0;
    assign pready         = 1'b1;
    assign text_attribute = text_attribute_reg;

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: transaction sequencer around the cell store.
// Depends on tcw_pkg, tcw_cell_ram and tcw_apb_regs.

// A text screen of ROWS x COLUMNS cells (25 x 80 by default) held in one
// synchronous RAM. Each input transaction is a put (character at the cursor,
// with LF, CR and TAB handled as control codes) or a read of one cell, and
// gives exactly one result transaction carrying the cursor position after it.
// Rows are addressed through a circular top-row pointer, so a scroll only
// blanks one physical row; a put that scrolls blanks it before its result is
// given. A read of a cell on the screen waits for the registered RAM read, a
// read outside the screen does not touch the RAM, and the controller handles
// one transaction at a time. The next transaction is accepted while a finished
// result waits at the output, but its own result then waits in the controller
// until the output register is free. After reset the controller blanks the
// whole RAM, one cell per cycle, before the first transaction is taken;
// configuration writes are accepted during that time.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ROW_W   = $clog2(ROWS)
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          command,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [ROW_W-1:0]              read_row,
    input  logic [COL_W-1:0]              read_col,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcw_pkg::CHAR_W-1:0]    cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]    cell_attr,
    output logic [COL_W-1:0]              cursor_col,
    output logic [ROW_W-1:0]              cursor_row,
    output logic                          scrolled,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::PDATA_W-1:0]   pwdata,
    output logic [tcw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [COL_W:0]      COLS_C    = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]      ROWS_C    = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0]   COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0]   LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [COL_W:0]      TAB_MASK  = (COL_W + 1)'(tcw_pkg::TAB_STOP - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_RESULT
    } state_t;

    state_t                      state_reg, state_next;
    logic [COL_W-1:0]            cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]            cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]            top_reg, top_next;
    logic [ADDR_W-1:0]           clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]           clr_end_reg, clr_end_next;
    logic                        cmd_reg, cmd_next;
    logic [tcw_pkg::CHAR_W-1:0]  ch_reg, ch_next;
    logic [ROW_W-1:0]            rd_row_reg, rd_row_next;
    logic [COL_W-1:0]            rd_col_reg, rd_col_next;
    logic [tcw_pkg::CHAR_W-1:0]  res_char_reg, res_char_next;
    logic [tcw_pkg::ATTR_W-1:0]  res_attr_reg, res_attr_next;
    logic                        res_scrolled_reg, res_scrolled_next;
    logic                        out_valid_reg, out_valid_next;
    logic [tcw_pkg::CHAR_W-1:0]  out_char_reg, out_char_next;
    logic [tcw_pkg::ATTR_W-1:0]  out_attr_reg, out_attr_next;
    logic [COL_W-1:0]            out_col_reg, out_col_next;
    logic [ROW_W-1:0]            out_row_reg, out_row_next;
    logic                        out_scrolled_reg, out_scrolled_next;

    logic [tcw_pkg::ATTR_W-1:0]  text_attribute;

    // Address path: logical row through the circular top-row pointer.
    logic [ROW_W-1:0]            row_sel;
    logic [COL_W-1:0]            col_sel;
    logic [ROW_W:0]              phys_sum;
    logic [ROW_W:0]              phys_row;
    logic [ADDR_W-1:0]           cell_addr;
    logic                        rd_in_range;

    // Cursor update for a put.
    logic [COL_W:0]              col_ext;
    logic [COL_W:0]              col_step;
    logic                        line_feed;
    logic                        store_char;
    logic                        wrap;
    logic                        new_line;
    logic                        at_bottom;
    logic                        do_scroll;
    logic [COL_W-1:0]            put_col;
    logic [ROW_W-1:0]            put_row;
    logic [ROW_W-1:0]            top_adv;
    logic [ADDR_W-1:0]           scroll_base;

    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [tcw_pkg::CELL_W-1:0]  mem_rdata;

    tcw_apb_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .text_attribute (text_attribute)
    );

    tcw_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cell_addr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        row_sel     = (cmd_reg == tcw_pkg::CMD_READ) ? rd_row_reg : cur_row_reg;
        col_sel     = (cmd_reg == tcw_pkg::CMD_READ) ? rd_col_reg : cur_col_reg;
        phys_sum    = {1'b0, row_sel} + {1'b0, top_reg};
        phys_row    = (phys_sum >= ROWS_C) ? (phys_sum - ROWS_C) : phys_sum;
        cell_addr   = ADDR_W'(phys_row) * COLS_A + ADDR_W'(col_sel);
        rd_in_range = ({1'b0, rd_row_reg} < ROWS_C) && ({1'b0, rd_col_reg} < COLS_C);
    end

    always_comb
    begin
        col_ext    = {1'b0, cur_col_reg};
        col_step   = '0;
        line_feed  = 1'b0;
        store_char = 1'b0;
        unique case (ch_reg)
            tcw_pkg::CH_LF:
            begin
                line_feed = 1'b1;
            end
            tcw_pkg::CH_TAB:
            begin
                col_step = (col_ext | TAB_MASK) + 1'b1;
            end
            tcw_pkg::CH_CR:
            begin
                col_step = '0;
            end
            default:
            begin
                store_char = 1'b1;
                col_step   = col_ext + 1'b1;
            end
        endcase
        wrap        = (col_step >= COLS_C);
        new_line    = line_feed || wrap;
        put_col     = wrap ? '0 : col_step[COL_W-1:0];
        at_bottom   = (cur_row_reg == LAST_ROW);
        do_scroll   = new_line && at_bottom;
        put_row     = (new_line && !at_bottom) ? cur_row_reg + 1'b1 : cur_row_reg;
        top_adv     = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
        // The old top row becomes the new bottom row and is blanked.
        scroll_base = ADDR_W'(top_reg) * COLS_A;
    end

    // Writes of one transaction finish before the next one reaches the RAM,
    // so a read never meets a write to the same cell in flight.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr;
        mem_wdata = {text_attribute, ch_reg};
        mem_re    = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = {tcw_pkg::BLANK_ATTR, tcw_pkg::BLANK_CHAR};
        end
        else if (state_reg == ST_EXEC)
        begin
            if (cmd_reg == tcw_pkg::CMD_PUT)
            begin
                mem_we = store_char;
            end
            else
            begin
                mem_re = rd_in_range;
            end
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        top_next          = top_reg;
        clr_addr_next     = clr_addr_reg;
        clr_end_next      = clr_end_reg;
        cmd_next          = cmd_reg;
        ch_next           = ch_reg;
        rd_row_next       = rd_row_reg;
        rd_col_next       = rd_col_reg;
        res_char_next     = res_char_reg;
        res_attr_next     = res_attr_reg;
        res_scrolled_next = res_scrolled_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        out_char_next     = out_char_reg;
        out_attr_next     = out_attr_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        out_scrolled_next = out_scrolled_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == clr_end_reg)
                begin
                    // The pass after reset has no transaction to report.
                    state_next = res_scrolled_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = command;
                    ch_next     = char_code;
                    rd_row_next = read_row;
                    rd_col_next = read_col;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_char_next     = '0;
                res_attr_next     = '0;
                res_scrolled_next = 1'b0;
                if (cmd_reg == tcw_pkg::CMD_READ)
                begin
                    state_next = rd_in_range ? ST_READ_WAIT : ST_RESULT;
                end
                else
                begin
                    cur_col_next      = put_col;
                    cur_row_next      = put_row;
                    res_scrolled_next = do_scroll;
                    if (do_scroll)
                    begin
                        top_next      = top_adv;
                        clr_addr_next = scroll_base;
                        clr_end_next  = scroll_base + COLS_A - 1'b1;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_READ_WAIT:
            begin
                res_char_next = mem_rdata[tcw_pkg::CHAR_W-1:0];
                res_attr_next = mem_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_char_next     = res_char_reg;
                    out_attr_next     = res_attr_reg;
                    out_col_next      = cur_col_reg;
                    out_row_next      = cur_row_reg;
                    out_scrolled_next = res_scrolled_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            top_reg          <= '0;
            clr_addr_reg     <= '0;
            clr_end_reg      <= LAST_CELL;
            cmd_reg          <= tcw_pkg::CMD_PUT;
            ch_reg           <= '0;
            rd_row_reg       <= '0;
            rd_col_reg       <= '0;
            res_char_reg     <= '0;
            res_attr_reg     <= '0;
            res_scrolled_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_char_reg     <= '0;
            out_attr_reg     <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_scrolled_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            top_reg          <= top_next;
            clr_addr_reg     <= clr_addr_next;
            clr_end_reg      <= clr_end_next;
            cmd_reg          <= cmd_next;
            ch_reg           <= ch_next;
            rd_row_reg       <= rd_row_next;
            rd_col_reg       <= rd_col_next;
            res_char_reg     <= res_char_next;
            res_attr_reg     <= res_attr_next;
            res_scrolled_reg <= res_scrolled_next;
            out_valid_reg    <= out_valid_next;
            out_char_reg     <= out_char_next;
            out_attr_reg     <= out_attr_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            out_scrolled_reg <= out_scrolled_next;
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_char  = out_char_reg;
    assign cell_attr  = out_attr_reg;
    assign cursor_col = out_col_reg;
    assign cursor_row = out_row_reg;
    assign scrolled   = out_scrolled_reg;

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_col_reg} < COLS_C)
        else $error("cursor column left the screen");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_row_reg} < ROWS_C)
        else $error("cursor row left the screen");

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, top_reg} < ROWS_C)
        else $error("top row pointer out of range");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_scrolled_reg) |-> (out_row_reg == LAST_ROW))
        else $error("scrolled result not on the last row");

    a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ_WAIT) |-> $past(mem_re))
        else $error("read wait without a RAM read");

endmodule

// ===== test/text_console_checker.sv =====
// Scoreboard for the text console writer: it watches the item, result and APB
// ports and keeps its own copy of the screen, cursor and attribute register.
// Depends on tcw_pkg only.
module text_console_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    parameter int COL_W   = $clog2(COLUMNS),
    parameter int ROW_W   = $clog2(ROWS)
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               command,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [ROW_W-1:0]   read_row,
    input  logic [COL_W-1:0]   read_col,

    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [CHAR_W-1:0]  cell_char,
    input  logic [ATTR_W-1:0]  cell_attr,
    input  logic [COL_W-1:0]   cursor_col,
    input  logic [ROW_W-1:0]   cursor_row,
    input  logic               scrolled,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,

    output int                 fail_count,
    output int                 pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * int'(REG_TEXT_ATTRIBUTE));

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic              scrolled;
    } console_result_t;

    logic [CELL_W-1:0] screen [ROWS*COLUMNS];
    int unsigned       col_now;
    int unsigned       row_now;
    logic [ATTR_W-1:0] attr_shadow;
    console_result_t   results_due [$];

    // Applies one transaction to the shadow screen and returns what the block should answer.
    function automatic console_result_t console_step(input logic cmd,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input int unsigned rrow,
                                                     input int unsigned rcol);
        console_result_t r;
        int i;
        r = '0;
        if (cmd == CMD_READ) begin
            if (rrow < ROWS && rcol < COLUMNS) begin
                r.cell_char = screen[rrow*COLUMNS + rcol][CHAR_W-1:0];
                r.cell_attr = screen[rrow*COLUMNS + rcol][CELL_W-1:CHAR_W];
            end
        end
        else begin
            if (ch == CH_LF) begin
                col_now = 0;
                row_now++;
            end
            else if (ch == CH_TAB) begin
                col_now = col_now + TAB_STOP - (col_now % TAB_STOP);
                if (col_now >= COLUMNS) begin
                    col_now = 0;
                    row_now++;
                end
            end
            else if (ch == CH_CR) begin
                col_now = 0;
            end
            else begin
                screen[row_now*COLUMNS + col_now] = {attr_shadow, ch};
                col_now++;
                if (col_now >= COLUMNS) begin
                    col_now = 0;
                    row_now++;
                end
            end
            if (row_now >= ROWS) begin
                for (i = 0; i < (ROWS-1)*COLUMNS; i++)
                    screen[i] = screen[i + COLUMNS];
                for (i = (ROWS-1)*COLUMNS; i < ROWS*COLUMNS; i++)
                    screen[i] = {BLANK_ATTR, BLANK_CHAR};
                row_now = ROWS - 1;
                r.scrolled = 1'b1;
            end
        end
        r.cursor_col = COL_W'(col_now);
        r.cursor_row = ROW_W'(row_now);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        console_result_t want;
        int i;
        if (!rst_n) begin
            for (i = 0; i < ROWS*COLUMNS; i++)
                screen[i] = {BLANK_ATTR, BLANK_CHAR};
            col_now         = 0;
            row_now         = 0;
            attr_shadow     = ATTR_RESET;
            fail_count      = 0;
            results_due.delete();
            pending_results = 0;
        end
        else begin
            if (psel && penable && pready && paddr == ATTR_ADDR) begin
                if (pwrite)
                    attr_shadow = pwdata[ATTR_W-1:0];
                else
                    check_field("prdata", 32'(attr_shadow), 32'(prdata[ATTR_W-1:0]));
            end
            if (in_valid && in_ready)
                results_due.push_back(console_step(command, char_code, read_row, read_col));
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result transaction with nothing expected, got col %0d row %0d",
                             $time, cursor_col, cursor_row);
                    fail_count++;
                end
                else begin
                    want = results_due.pop_front();
                    check_field("cell_char", 32'(want.cell_char), 32'(cell_char));
                    check_field("cell_attr", 32'(want.cell_attr), 32'(cell_attr));
                    check_field("cursor_col", 32'(want.cursor_col), 32'(cursor_col));
                    check_field("cursor_row", 32'(want.cursor_row), 32'(cursor_row));
                    check_field("scrolled", 32'(want.scrolled), 32'(scrolled));
                end
            end
            pending_results = results_due.size();
        end
    end

endmodule

// ===== test/tb_text_console_writer.sv =====
// Top of the text console writer testbench: clock, reset, item and APB stimulus,
// watchdog and verdict. Depends on tcw_pkg, text_console_writer and text_console_checker.
module tb_text_console_writer;
    import tcw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COL_W       = $clog2(COLUMNS_DEF);
    localparam int ROW_W       = $clog2(ROWS_DEF);
    localparam int PHASE_ITEMS = 460;
    localparam int STALL_LIMIT = 20000;
    localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(4 * int'(REG_TEXT_ATTRIBUTE));

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               command;
    logic [CHAR_W-1:0]  char_code;
    logic [ROW_W-1:0]   read_row;
    logic [COL_W-1:0]   read_col;
    logic               out_valid;
    logic               out_ready;
    logic [CHAR_W-1:0]  cell_char;
    logic [ATTR_W-1:0]  cell_attr;
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic               scrolled;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending_results;
    int quiet_cycles = 0;
    bit gaps_on = 1'b1;

    always #6 clk = ~clk;

    text_console_writer uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .char_code(char_code), .read_row(read_row), .read_col(read_col),
        .out_valid(out_valid), .out_ready(out_ready), .cell_char(cell_char),
        .cell_attr(cell_attr), .cursor_col(cursor_col), .cursor_row(cursor_row),
        .scrolled(scrolled),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    text_console_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .char_code(char_code), .read_row(read_row), .read_col(read_col),
        .out_valid(out_valid), .out_ready(out_ready), .cell_char(cell_char),
        .cell_attr(cell_attr), .cursor_col(cursor_col), .cursor_row(cursor_row),
        .scrolled(scrolled),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    always @(posedge clk)
        out_ready <= gaps_on ? ($urandom_range(99) >= 22) : 1'b1;

    // Ends the run when neither channel has moved a transaction for too long.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Called at a rising edge; returns at the rising edge that accepted the transaction.
    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rrow, input logic [COL_W-1:0] rcol);
        logic taken;
        if (gaps_on && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        command   <= cmd;
        char_code <= ch;
        read_row  <= rrow;
        read_col  <= rcol;
        do begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end while (!taken);
    endtask

    task automatic send_random_item();
        int pick;
        logic [CHAR_W-1:0] ch;
        pick = $urandom_range(99);
        ch   = CHAR_W'($urandom_range(255));
        if (pick < 35) begin
            if ($urandom_range(4) == 0)
                send_item(CMD_READ, ch, ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
            else
                send_item(CMD_READ, ch, ROW_W'($urandom_range(ROWS_DEF-1)),
                          COL_W'($urandom_range(COLUMNS_DEF-1)));
        end
        else begin
            if (pick < 41)
                ch = CH_LF;
            else if (pick < 47)
                ch = CH_TAB;
            else if (pick < 50)
                ch = CH_CR;
            send_item(CMD_PUT, ch, ROW_W'($urandom_range(31)), COL_W'($urandom_range(127)));
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results != 0);
        @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ATTR_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [ATTR_W-1:0] attr, input bit with_gaps,
                             input bit hold_midway);
        drain_results();
        apb_access(1'b1, PDATA_W'(attr));
        apb_access(1'b0, '0);
        gaps_on = with_gaps;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (hold_midway && n == PHASE_ITEMS / 2)
                drain_results();
            send_random_item();
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = CMD_PUT;
        char_code = '0;
        read_row  = '0;
        read_col  = '0;
        out_ready = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value of the attribute register, then the directed transactions.
        apb_access(1'b0, '0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_item(CMD_READ, 8'hFF, 5'd31, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd127);
        send_item(CMD_READ, 8'h00, 5'd24, 7'd79);
        send_item(CMD_READ, 8'h00, 5'd25, 7'd80);
        send_item(CMD_PUT, 8'h41, 5'd31, 7'd127);
        send_item(CMD_PUT, 8'h00, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'hFF, 5'd0, 7'd0);
        send_item(CMD_PUT, CH_TAB, 5'd0, 7'd0);
        send_item(CMD_PUT, CH_CR, 5'd0, 7'd0);
        send_item(CMD_PUT, CH_LF, 5'd0, 7'd0);
        // Ten tabs from column 0: the last one runs past the end of the row and wraps.
        repeat (10) send_item(CMD_PUT, CH_TAB, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd1);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd2);

        run_phase(8'h00, 1'b1, 1'b0);
        run_phase(8'hFF, 1'b0, 1'b0);
        run_phase(ATTR_W'($urandom_range(255)), 1'b1, 1'b1);
        run_phase(8'h5A, 1'b1, 1'b0);

        drain_results();
        repeat (2 * (3 + COLUMNS_DEF)) @(posedge clk);
        if (fail_count == 0 && pending_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== text_console_writer.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/tcw_apb_regs.sv
hw/rtl/text_console_writer.sv
test/text_console_checker.sv
test/tb_text_console_writer.sv
